// File: design/preemptive_priority_scheduler_assert.svh
// assertion macros for the preemptive priority scheduler
// no dependencies; included by the top level only
`ifndef PREEMPTIVE_PRIORITY_SCHEDULER_ASSERT_SVH
`define PREEMPTIVE_PRIORITY_SCHEDULER_ASSERT_SVH
`ifndef SYNTHESIS
// condition a in one cycle implies condition b in the next cycle
`define PPS_ASSERT_NEXT(lbl, clk, rst_n, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("pps: next-cycle check failed");
// condition a implies condition b in the same cycle
`define PPS_ASSERT_SAME(lbl, clk, rst_n, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("pps: same-cycle check failed");
`else
`define PPS_ASSERT_NEXT(lbl, clk, rst_n, a, b)
`define PPS_ASSERT_SAME(lbl, clk, rst_n, a, b)
`endif
`endif

// File: design/pps_pkg.sv
// shared types and constants of the preemptive priority scheduler
// no dependencies; used by pps_ctrl, pps_dp and the top level
`default_nettype none
package pps_pkg;

  localparam int MAX_TASKS_DEF = 16;
  localparam int SLOT_W        = 4;
  localparam int TIME_W        = 16;
  localparam int PRI_W         = 8;
  localparam int TASK_W        = 5;
  localparam int IN_TDATA_W    = 48;
  localparam int OUT_TDATA_W   = 104;

  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  // command codes carried in in_tuser
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CMP,
    ST_UPD,
    ST_RES
  } pps_state_t;

  typedef struct packed {
    logic load_wr;
    logic scan_start;
    logic scan_rd;
    logic update;
    logic result_ld;
  } pps_cmd_t;

  typedef struct packed {
    logic last_rd;
    logic out_free;
  } pps_sts_t;

endpackage
`default_nettype wire

// File: design/preemptive_priority_scheduler.sv
// Preemptive priority scheduler. A load transaction (in_tuser = 0) writes one task into its
// table slot and returns nothing; slots at or beyond MAX_TASKS are ignored.
// A tick transaction (in_tuser = 1) picks, among loaded tasks that have arrived and still
// have units left, the one with the smallest priority value (ties: earlier arrival, then
// lower slot), runs it one unit and returns one result transaction. The task memories
// have a single registered read port and are scanned one slot per cycle, followed by
// a compare, an update and a result state; the result state stalls while the previous
// result is still held in the output register.
// The time counter saturates at 65535. No clearing pass is needed after reset.
`default_nettype none
`include "preemptive_priority_scheduler_assert.svh"
module preemptive_priority_scheduler #(
  parameter int MAX_TASKS = pps_pkg::MAX_TASKS_DEF
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_tvalid,
  output logic                             in_tready,
  // slot[3:0], arrival[19:4], burst[35:20], priority_req[43:36], zero fill[47:44]
  input  wire [pps_pkg::IN_TDATA_W-1:0]    in_tdata,
  // cmd[0]
  input  wire                              in_tuser,
  output logic                             out_tvalid,
  input  wire                              out_tready,
  // now[15:0], task_number[20:16], left[36:21], done_units[52:37], finished[53],
  // finish_time[69:54], turnaround[85:70], waiting[101:86], all_done[102], zero fill[103]
  output logic [pps_pkg::OUT_TDATA_W-1:0]  out_tdata,
  // idle[0]
  output logic                             out_tuser
);
  import pps_pkg::*;

  pps_cmd_t ctl_cmd;
  pps_sts_t dp_sts;
  logic     in_fire;

  // input field unpacking
  logic [SLOT_W-1:0] in_slot;
  logic [TIME_W-1:0] in_arrival;
  logic [TIME_W-1:0] in_burst;
  logic [PRI_W-1:0]  in_priority;

  assign in_slot     = in_tdata[3:0];
  assign in_arrival  = in_tdata[19:4];
  assign in_burst    = in_tdata[35:20];
  assign in_priority = in_tdata[43:36];

  assign in_fire = in_tvalid && in_tready;

  // sequencer: idle, scan, compare, update, result
  pps_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .in_cmd   (in_tuser),
    .sts      (dp_sts),
    .in_ready (in_tready),
    .cmd      (ctl_cmd)
  );

  // task table, scan compare, time counter and output register
  pps_dp #(
    .MAX_TASKS (MAX_TASKS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (ctl_cmd),
    .sts         (dp_sts),
    .in_slot     (in_slot),
    .in_arrival  (in_arrival),
    .in_burst    (in_burst),
    .in_priority (in_priority),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser)
  );

  // a tick transaction blocks further input until its result is loaded
  `PPS_ASSERT_NEXT(a_tick_blocks, clk, rst_n, in_fire && in_tuser == CMD_TICK, !in_tready)
  // a result is only loaded into a free output register
  `PPS_ASSERT_SAME(a_ld_free, clk, rst_n, ctl_cmd.result_ld, dp_sts.out_free)
  // a loaded result is presented in the next cycle
  `PPS_ASSERT_NEXT(a_ld_shows, clk, rst_n, ctl_cmd.result_ld, out_tvalid)
  // a scan always starts with a read of the first slot
  `PPS_ASSERT_NEXT(a_scan_reads, clk, rst_n, ctl_cmd.scan_start, ctl_cmd.scan_rd)

endmodule
`default_nettype wire

// File: design/pps_ctrl.sv
// controller state machine of the preemptive priority scheduler
// depends on pps_pkg; drives pps_dp through pps_cmd_t
`default_nettype none
module pps_ctrl (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_fire,
  input  wire               in_cmd,
  input  pps_pkg::pps_sts_t sts,
  output logic              in_ready,
  output pps_pkg::pps_cmd_t cmd
);
  import pps_pkg::*;

  pps_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire && in_cmd == CMD_TICK) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (sts.last_rd) state_nxt = ST_CMP;
      end
      ST_CMP:  state_nxt = ST_UPD;
      ST_UPD:  state_nxt = ST_RES;
      ST_RES: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready       = 1'b1;
        cmd.load_wr    = in_fire && in_cmd == CMD_LOAD;
        cmd.scan_start = in_fire && in_cmd == CMD_TICK;
      end
      ST_SCAN: cmd.scan_rd   = 1'b1;
      ST_CMP:  cmd           = '0;
      ST_UPD:  cmd.update    = 1'b1;
      ST_RES:  cmd.result_ld = sts.out_free;
      default: cmd           = '0;
    endcase
  end

endmodule
`default_nettype wire

// File: design/pps_dp.sv
// datapath of the preemptive priority scheduler: task memories, scan, result register
// depends on pps_pkg; commanded by pps_ctrl
`default_nettype none
module pps_dp #(
  parameter int MAX_TASKS = pps_pkg::MAX_TASKS_DEF
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  pps_pkg::pps_cmd_t                   cmd,
  output pps_pkg::pps_sts_t                   sts,
  input  wire [pps_pkg::SLOT_W-1:0]           in_slot,
  input  wire [pps_pkg::TIME_W-1:0]           in_arrival,
  input  wire [pps_pkg::TIME_W-1:0]           in_burst,
  input  wire [pps_pkg::PRI_W-1:0]            in_priority,
  output logic                                out_tvalid,
  input  wire                                 out_tready,
  output logic [pps_pkg::OUT_TDATA_W-1:0]     out_tdata,
  output logic                                out_tuser
);
  import pps_pkg::*;

  localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CW = IW + 1;
  localparam int XW = ((IW > SLOT_W) ? IW : SLOT_W) + 1;
  localparam int AW = $clog2(MAX_TASKS + 1);

  // task memories, undefined until loaded
  logic [TIME_W-1:0] arr_mem   [MAX_TASKS];
  logic [TIME_W-1:0] burst_mem [MAX_TASKS];
  logic [PRI_W-1:0]  pri_mem   [MAX_TASKS];
  logic [TIME_W-1:0] rem_mem   [MAX_TASKS];
  logic [MAX_TASKS-1:0] valid_r;

  logic [TIME_W-1:0] clock_r;
  logic [CW-1:0]     cnt_r;
  logic              rd_vld_r;
  logic [IW-1:0]     rd_idx_r;
  logic              vbit_rd_r;
  logic [TIME_W-1:0] arr_rd_r, burst_rd_r, rem_rd_r;
  logic [PRI_W-1:0]  pri_rd_r;

  logic              found_r;
  logic [IW-1:0]     best_idx_r;
  logic [TIME_W-1:0] best_arr_r, best_burst_r, best_rem_r;
  logic [PRI_W-1:0]  best_pri_r;
  logic [AW-1:0]     act_cnt_r;

  logic [TIME_W-1:0] fin_r, left_r, turn_r;
  logic              all_done_r;

  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic                   out_idle_r;

  logic [XW-1:0]     slot_x;
  logic              slot_ok;
  logic [IW-1:0]     wr_idx;
  logic [IW-1:0]     rd_idx;
  logic              active, eligible, better, last_fin;
  logic [TIME_W-1:0] left_nxt, done_v, wait_v, fin_out, turn_out, wait_out, left_out;
  logic [TASK_W-1:0] task_v;
  logic              finished_v;

  assign slot_x  = XW'(in_slot);
  assign slot_ok = slot_x < XW'(MAX_TASKS);
  assign wr_idx  = slot_x[IW-1:0];
  assign rd_idx  = cnt_r[IW-1:0];

  // memories: one write port, one registered read port each
  always_ff @(posedge clk) begin
    if (cmd.load_wr && slot_ok) arr_mem[wr_idx] <= in_arrival;
    if (cmd.scan_rd) arr_rd_r <= arr_mem[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_wr && slot_ok) burst_mem[wr_idx] <= in_burst;
    if (cmd.scan_rd) burst_rd_r <= burst_mem[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_wr && slot_ok) pri_mem[wr_idx] <= in_priority;
    if (cmd.scan_rd) pri_rd_r <= pri_mem[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_wr && slot_ok) begin
      rem_mem[wr_idx] <= in_burst;
    end else if (cmd.update && found_r) begin
      rem_mem[best_idx_r] <= left_nxt;
    end
    if (cmd.scan_rd) rem_rd_r <= rem_mem[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (cmd.load_wr && slot_ok) begin
      valid_r[wr_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_rd) begin
      vbit_rd_r <= valid_r[rd_idx];
      rd_idx_r  <= rd_idx;
    end
  end

  // scan: compare one slot per cycle against the running best
  assign active   = rd_vld_r && vbit_rd_r && rem_rd_r != '0;
  assign eligible = active && arr_rd_r <= clock_r;
  assign better   = !found_r || pri_rd_r < best_pri_r ||
                    (pri_rd_r == best_pri_r && arr_rd_r < best_arr_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      rd_vld_r <= 1'b0;
      found_r  <= 1'b0;
    end else begin
      rd_vld_r <= cmd.scan_rd;
      if (cmd.scan_start) begin
        cnt_r   <= '0;
        found_r <= 1'b0;
      end else begin
        if (cmd.scan_rd) cnt_r <= cnt_r + CW'(1);
        if (eligible && better) found_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      act_cnt_r <= '0;
      fin_r     <= (clock_r == TIME_MAX) ? clock_r : clock_r + TIME_W'(1);
    end else begin
      if (active) act_cnt_r <= act_cnt_r + AW'(1);
      if (eligible && better) begin
        best_idx_r   <= rd_idx_r;
        best_arr_r   <= arr_rd_r;
        best_burst_r <= burst_rd_r;
        best_rem_r   <= rem_rd_r;
        best_pri_r   <= pri_rd_r;
      end
    end
  end

  assign sts.last_rd = cnt_r == CW'(MAX_TASKS - 1);

  // update: one unit off the picked task
  assign left_nxt = best_rem_r - TIME_W'(1);
  assign last_fin = found_r && left_nxt == '0;

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      left_r     <= left_nxt;
      turn_r     <= (fin_r >= best_arr_r) ? fin_r - best_arr_r : '0;
      all_done_r <= (act_cnt_r - AW'(last_fin)) == '0;
    end
  end

  // result fields
  assign finished_v = found_r && left_r == '0;
  assign done_v     = best_burst_r - left_r;
  assign wait_v     = (turn_r >= best_burst_r) ? turn_r - best_burst_r : '0;
  assign task_v     = found_r ? TASK_W'(best_idx_r) + TASK_W'(1) : '0;
  assign left_out   = found_r ? left_r : '0;
  assign fin_out    = finished_v ? fin_r : '0;
  assign turn_out   = finished_v ? turn_r : '0;
  assign wait_out   = finished_v ? wait_v : '0;

  assign sts.out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      clock_r     <= '0;
    end else begin
      if (cmd.result_ld) begin
        out_valid_r <= 1'b1;
        clock_r     <= (clock_r == TIME_MAX) ? clock_r : clock_r + TIME_W'(1);
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.result_ld) begin
      out_idle_r <= !found_r;
      out_data_r <= {1'b0, all_done_r, wait_out, turn_out, fin_out, finished_v,
                     (found_r ? done_v : TIME_W'(0)), left_out, task_v, clock_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_idle_r;

endmodule
`default_nettype wire

// File: dv/pps_schedule_checker.sv
// scoreboard for the preemptive priority scheduler: watches both stream channels,
// predicts every tick report from its own copy of the task table and compares it
// depends on pps_pkg for the command codes and the port widths
`timescale 1ns / 1ps
module pps_schedule_checker (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_tvalid,
  input  wire                              in_tready,
  input  wire [pps_pkg::IN_TDATA_W-1:0]    in_tdata,
  input  wire                              in_tuser,
  input  wire                              out_tvalid,
  input  wire                              out_tready,
  input  wire [pps_pkg::OUT_TDATA_W-1:0]   out_tdata,
  input  wire                              out_tuser,
  output int                               mismatches,
  output int                               pending,
  output int                               reports_seen,
  output int                               idle_seen,
  output int                               completions_seen
);

  localparam int NSLOTS = pps_pkg::MAX_TASKS_DEF;
  localparam logic [15:0] TMAX = pps_pkg::TIME_MAX;

  typedef struct packed {
    logic [15:0] now;
    logic        idle;
    logic [4:0]  task_no;
    logic [15:0] left;
    logic [15:0] done_units;
    logic        finished;
    logic [15:0] fin_time;
    logic [15:0] turnaround;
    logic [15:0] waiting;
    logic        all_done;
  } tick_report_t;

  // shadow task table
  logic [15:0] task_arrival [NSLOTS];
  logic [15:0] task_burst   [NSLOTS];
  logic [15:0] task_left    [NSLOTS];
  logic [7:0]  task_prio    [NSLOTS];
  logic        task_loaded  [NSLOTS];
  logic [15:0] sched_time;

  tick_report_t expected_reports[$];
  tick_report_t rep;
  logic [3:0]   load_slot;
  int           n;

  task automatic predict_tick_report(output tick_report_t r);
    int          k;
    int          pick;
    bit          found;
    logic [15:0] t;
    logic [15:0] fin;
    logic [15:0] turn;
    pick = 0;
    found = 1'b0;
    t = sched_time;
    r = '0;
    r.now = t;
    for (k = 0; k < NSLOTS; k++) begin
      if (task_loaded[k] && task_left[k] != 0 && task_arrival[k] <= t) begin
        if (!found || task_prio[k] < task_prio[pick] ||
            (task_prio[k] == task_prio[pick] && task_arrival[k] < task_arrival[pick])) begin
          pick = k;
          found = 1'b1;
        end
      end
    end
    if (!found) begin
      r.idle = 1'b1;
    end else begin
      task_left[pick] = task_left[pick] - 16'd1;
      r.task_no = 5'(pick + 1);
      r.left = task_left[pick];
      r.done_units = task_burst[pick] - task_left[pick];
      if (task_left[pick] == 0) begin
        fin = (t != TMAX) ? t + 16'd1 : TMAX;
        turn = (fin >= task_arrival[pick]) ? fin - task_arrival[pick] : 16'd0;
        r.finished = 1'b1;
        r.fin_time = fin;
        r.turnaround = turn;
        // only goes negative once the clock has saturated
        r.waiting = (turn >= task_burst[pick]) ? turn - task_burst[pick] : 16'd0;
      end
    end
    r.all_done = 1'b1;
    for (k = 0; k < NSLOTS; k++)
      if (task_loaded[k] && task_left[k] != 0) r.all_done = 1'b0;
    sched_time = (t != TMAX) ? t + 16'd1 : TMAX;
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (n = 0; n < NSLOTS; n++) begin
        task_loaded[n] = 1'b0;
        task_arrival[n] = '0;
        task_burst[n] = '0;
        task_left[n] = '0;
        task_prio[n] = '0;
      end
      sched_time = '0;
      expected_reports.delete();
    end else begin
      if (in_tvalid && in_tready) begin
        if (in_tuser == pps_pkg::CMD_TICK) begin
          predict_tick_report(rep);
          expected_reports.push_back(rep);
        end else begin
          load_slot = in_tdata[3:0];
          if (int'(load_slot) < NSLOTS) begin
            task_arrival[load_slot] = in_tdata[19:4];
            task_burst[load_slot] = in_tdata[35:20];
            task_left[load_slot] = in_tdata[35:20];
            task_prio[load_slot] = in_tdata[43:36];
            task_loaded[load_slot] = 1'b1;
          end
        end
      end
      if (out_tvalid && out_tready) begin
        if (expected_reports.size() == 0) begin
          $error("tick report arrived with no tick outstanding");
          mismatches++;
        end else begin
          rep = expected_reports.pop_front();
          check_field("now", rep.now, out_tdata[15:0]);
          check_field("idle", rep.idle, out_tuser);
          check_field("task_number", rep.task_no, out_tdata[20:16]);
          check_field("left", rep.left, out_tdata[36:21]);
          check_field("done_units", rep.done_units, out_tdata[52:37]);
          check_field("finished", rep.finished, out_tdata[53]);
          check_field("finish_time", rep.fin_time, out_tdata[69:54]);
          check_field("turnaround", rep.turnaround, out_tdata[85:70]);
          check_field("waiting", rep.waiting, out_tdata[101:86]);
          check_field("all_done", rep.all_done, out_tdata[102]);
          reports_seen++;
          if (rep.idle) idle_seen++;
          if (rep.finished) completions_seen++;
        end
      end
    end
    pending = expected_reports.size();
  end

endmodule

// File: dv/tb_preemptive_priority_scheduler.sv
// top of the scheduler testbench: clock, reset, load/tick stimulus, result sink and verdict
// depends on pps_pkg, the preemptive_priority_scheduler rtl and pps_schedule_checker
`timescale 1ns / 1ps
module tb_preemptive_priority_scheduler;

  localparam int RANDOM_ITEMS  = 900;
  localparam int HOLD_CYCLES   = 300;     // long receiver hold-off
  localparam int TICK_CYCLES   = pps_pkg::MAX_TASKS_DEF + 4;
  localparam int TAIL_CYCLES   = 4 * TICK_CYCLES;
  localparam int CYCLE_LIMIT   = 5_000_000;
  localparam int TIME_TOP      = 65535;

  logic                            clk;
  logic                            rst_n;
  logic                            in_tvalid;
  logic                            in_tready;
  logic [pps_pkg::IN_TDATA_W-1:0]  in_tdata;
  logic                            in_tuser;
  logic                            out_tvalid;
  logic                            out_tready;
  logic [pps_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                            out_tuser;

  int mismatches;
  int pending;
  int reports_seen;
  int idle_seen;
  int completions_seen;

  // shared between stimulus and sink
  bit no_gaps;        // both sides run without idle cycles
  bit hold_request;   // set by stimulus, cleared by the sink after the hold-off

  int loads_sent;
  int ticks_sent;
  int cycle_count;

  preemptive_priority_scheduler dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  pps_schedule_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_tvalid        (in_tvalid),
    .in_tready        (in_tready),
    .in_tdata         (in_tdata),
    .in_tuser         (in_tuser),
    .out_tvalid       (out_tvalid),
    .out_tready       (out_tready),
    .out_tdata        (out_tdata),
    .out_tuser        (out_tuser),
    .mismatches       (mismatches),
    .pending          (pending),
    .reports_seen     (reports_seen),
    .idle_seen        (idle_seen),
    .completions_seen (completions_seen)
  );

  // 10 ns clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // scheduler clock as the block sees it: one step per tick, saturating
  function automatic int sched_now();
    return (ticks_sent > TIME_TOP) ? TIME_TOP : ticks_sent;
  endfunction

  // drive one transaction after a random gap, return once it is accepted
  task automatic send_item(input logic cmd, input logic [43:0] payload);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 5);
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {4'b0, payload};
    do @(posedge clk); while (!in_tready);
    if (cmd == pps_pkg::CMD_TICK) ticks_sent++;
    else loads_sent++;
  endtask

  task automatic load_task(input logic [3:0] slot, input logic [15:0] arrival,
                           input logic [15:0] burst, input logic [7:0] prio);
    send_item(pps_pkg::CMD_LOAD, {prio, burst, arrival, slot});
  endtask

  // tick with junk in the unused fields
  task automatic tick();
    send_item(pps_pkg::CMD_TICK, {12'($urandom_range(0, 4095)), 32'($urandom)});
  endtask

  // mostly short tasks arriving around the current time, sometimes full-range noise
  task automatic random_load(inout int work);
    logic [3:0]  slot;
    logic [7:0]  prio;
    logic [15:0] burst;
    int          arrival;
    slot = 4'($urandom_range(0, 15));
    // narrow priorities now and then so ties actually happen
    prio = $urandom_range(0, 1) ? 8'($urandom_range(0, 3)) : 8'($urandom_range(0, 255));
    if ($urandom_range(0, 7) == 0) begin
      arrival = $urandom_range(0, TIME_TOP);
      burst = 16'($urandom_range(1, 65535));
    end else begin
      arrival = (sched_now() > 2) ? sched_now() - 2 + $urandom_range(0, 8)
                                  : $urandom_range(0, 8);
      if (arrival > TIME_TOP) arrival = TIME_TOP;
      burst = 16'($urandom_range(1, 6));
      work += burst;
    end
    load_task(slot, 16'(arrival), burst, prio);
  endtask

  // stop offering and wait until every tick has reported back
  task automatic drain_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // result sink: random stall per transaction, plus the long hold-off on request
  initial begin : result_sink
    int wait_left;
    int held;
    out_tready = 1'b0;
    wait_left = 0;
    held = 0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_tready <= 1'b0;
        held++;
        if (held >= HOLD_CYCLES) begin
          hold_request = 1'b0;
          held = 0;
        end
      end else if (wait_left > 0) begin
        out_tready <= 1'b0;
        wait_left--;
      end else begin
        out_tready <= 1'b1;
      end
      @(posedge clk);
      if (out_tvalid && out_tready) wait_left = no_gaps ? 0 : $urandom_range(0, 5);
    end
  end

  // watchdog
  initial begin
    for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) @(posedge clk);
    $display("timeout after %0d cycles, %0d ticks still outstanding", cycle_count, pending);
    $display("FAIL");
    $finish;
  end

  // stimulus and verdict
  initial begin : stimulus
    int batch;
    int work;
    int spare;
    int n_ticks;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = pps_pkg::CMD_LOAD;
    no_gaps = 1'b0;
    hold_request = 1'b0;
    loads_sent = 0;
    ticks_sent = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty table first, so the tick is idle with all_done set
    tick();
    // equal priority, equal arrival: lower slot wins
    load_task(4'd15, 16'd0, 16'd2, 8'd255);
    load_task(4'd0, 16'd0, 16'd1, 8'd255);
    // urgent task arriving later preempts
    load_task(4'd3, 16'd2, 16'd3, 8'd0);
    // same priority, later arrival in a lower slot loses to slot 15
    load_task(4'd7, 16'd1, 16'd1, 8'd255);
    // field extremes: never arrives during the directed part
    load_task(4'd9, 16'hffff, 16'hffff, 8'd0);
    repeat (5) tick();
    // reload a running task: it restarts from its full burst
    load_task(4'd15, 16'd0, 16'd1, 8'd255);
    repeat (4) tick();
    // replace the far-future task so the table can empty out
    load_task(4'd9, 16'd0, 16'd1, 8'd128);
    repeat (3) tick();
    // everything finished: idle tick with all_done
    tick();

    // random batches of loads followed by enough ticks to work them off
    batch = 0;
    while (loads_sent + ticks_sent < 22 + RANDOM_ITEMS) begin
      no_gaps = ($urandom_range(0, 5) == 0);
      // receiver stops for a long time while the sender keeps pushing
      if (batch == 8) hold_request = 1'b1;
      if (batch % 20 == 19) drain_results();
      work = 0;
      spare = 0;
      repeat ($urandom_range(1, 5)) random_load(work);
      n_ticks = work + $urandom_range(0, 4);
      repeat (n_ticks) begin
        // occasional late arrival in the middle of a run
        if ($urandom_range(0, 9) == 0) random_load(spare);
        tick();
      end
      batch++;
    end

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("sent %0d loads and %0d ticks; %0d reports checked, %0d idle, %0d completions",
             loads_sent, ticks_sent, reports_seen, idle_seen, completions_seen);
    $display("included a %0d-cycle receiver hold-off and periodic full drains",
             HOLD_CYCLES);
    if (mismatches == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
